// File: src/assert_macros.svh
// Assertion macros shared by the frame bitmap allocator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk, switched off while rst_n is low.
`define FBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define FBA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBA_ASSERT(lbl, prop, msg)
`define FBA_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// File: src/fba_pkg.sv
// Package of the frame bitmap allocator: field widths, codes and the
// controller/datapath interface structs. No dependencies.
`default_nettype none

package fba_pkg;

  localparam int FRAME_W      = 12;
  localparam int CFG_W        = 13;
  localparam int FIELD_FRAMES = 4096;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'h1000;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MAPPED  = 2'd1;
  localparam logic [1:0] STAT_NO_FREE = 2'd2;
  localparam logic [1:0] STAT_RANGE   = 2'd3;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_MAPPED,
    RES_NO_FREE,
    RES_RANGE,
    RES_ALLOC,
    RES_TEST
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      clear;
    logic      accept;
    logic      scan;
    logic      lookup;
    logic      free_wr;
    logic      alloc_wr;
    logic      finish;
    res_kind_t res_kind;
  } fba_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       clear_last;
    logic [1:0] cmd;
    logic       entry_nz;
    logic       in_range;
    logic       chk_vld;
    logic       found;
    logic       last_word;
  } fba_stat_t;

endpackage

`default_nettype wire

// File: src/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: ties the controller to the datapath.
// Depends on fba_pkg, fba_ctrl and fba_datapath.
`default_nettype none

// First-fit physical frame allocator keeping one used bit per 4 KiB frame in a
// bitmap memory of WORD_BITS-bit words. A transaction is accepted on a rising
// edge where start is high and busy is low; its result appears on the out_
// ports for exactly one cycle with out_valid high, and the receiver cannot
// stall it, so the result must be captured in that cycle. The next transaction
// may be accepted in the same cycle the previous result is shown. After reset
// the block sweeps the bitmap to zero, one word per cycle, and keeps busy high
// until the sweep is done; cfg_we writes are still taken during the sweep.
// Allocate (command 0) scans the bitmap one word per cycle from frame 0 up to
// the first free frame, examining at most ceil(limit/WORD_BITS) words, then
// marks that frame used and returns it. A mapped entry, an unused command, or
// an out-of-range frame is answered from the decode state. Free (command 1)
// and test (command 2) read one bitmap word in the lookup state and answer in
// the check state, where free also rewrites the word with the frame's bit
// cleared. The searched range is frames below the smaller of the frames_in_use
// register (cfg_wdata, reset 4096) and min(NUM_FRAMES,4096); write it only
// while no transaction is in progress.
module frame_bitmap_allocator import fba_pkg::*; #(
  parameter int NUM_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_command,
  input  wire logic [FRAME_W-1:0] in_entry_frame,
  input  wire logic [FRAME_W-1:0] in_query_frame,
  input  wire logic               in_is_kernel,
  input  wire logic               in_is_writable,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [FRAME_W-1:0]      out_new_frame,
  output logic                    out_present,
  output logic                    out_user_access,
  output logic                    out_writable,
  output logic                    out_frame_used,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  // Command and status bundles between the sequencer and the datapath.
  fba_ctl_t  ctl;
  fba_stat_t stat;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl),
    .stat      (stat)
  );

  // The datapath owns the bitmap memory, the frames_in_use register and the
  // result registers, which hold their value until the next result.
  fba_datapath #(
    .NUM_FRAMES (NUM_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_command      (in_command),
    .in_entry_frame  (in_entry_frame),
    .in_query_frame  (in_query_frame),
    .in_is_kernel    (in_is_kernel),
    .in_is_writable  (in_is_writable),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_status      (out_status),
    .out_new_frame   (out_new_frame),
    .out_present     (out_present),
    .out_user_access (out_user_access),
    .out_writable    (out_writable),
    .out_frame_used  (out_frame_used)
  );

endmodule

`default_nettype wire

// File: src/fba_datapath.sv
// Datapath of the frame bitmap allocator: bitmap memory, scan counters,
// word/bit split of a frame number and result registers. Uses fba_pkg.
`default_nettype none
`include "assert_macros.svh"

module fba_datapath import fba_pkg::*; #(
  parameter int NUM_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fba_ctl_t           ctl,
  output fba_stat_t               stat,
  input  wire logic [1:0]         in_command,
  input  wire logic [FRAME_W-1:0] in_entry_frame,
  input  wire logic [FRAME_W-1:0] in_query_frame,
  input  wire logic               in_is_kernel,
  input  wire logic               in_is_writable,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  output logic [1:0]              out_status,
  output logic [FRAME_W-1:0]      out_new_frame,
  output logic                    out_present,
  output logic                    out_user_access,
  output logic                    out_writable,
  output logic                    out_frame_used
);

  // Frames above the 12-bit field range can never be reached.
  localparam int MAP_FRAMES = (NUM_FRAMES < FIELD_FRAMES) ? NUM_FRAMES : FIELD_FRAMES;
  localparam int MAP_DEPTH  = (MAP_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int CNT_W      = $clog2(MAP_DEPTH + 1);
  localparam int BIT_W      = $clog2(WORD_BITS);
  // Exact division of a 12-bit frame number by WORD_BITS via reciprocal.
  localparam int SH         = FRAME_W + BIT_W;
  localparam int RECIP      = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W    = FRAME_W + 2;
  localparam int PROD_W     = FRAME_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [WORD_BITS-1:0] map_mem [MAP_DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  logic [1:0]           cmd_r;
  logic [FRAME_W-1:0]   entry_r;
  logic [FRAME_W-1:0]   query_r;
  logic                 kern_r;
  logic                 wr_r;
  logic [CFG_W-1:0]     cfg_frames_r;

  logic [ADDR_W-1:0]    q_r;
  logic [BIT_W-1:0]     rem_r;
  logic [ADDR_W-1:0]    clr_idx_r;
  logic [CNT_W-1:0]     rd_idx_r;
  logic [CFG_W-1:0]     rd_base_r;
  logic [ADDR_W-1:0]    chk_idx_r;
  logic [CFG_W-1:0]     chk_base_r;
  logic                 chk_vld_r;

  logic [1:0]           status_r;
  logic [FRAME_W-1:0]   new_frame_r;
  logic                 present_r;
  logic                 user_r;
  logic                 writable_r;
  logic                 used_r;

  logic [CFG_W-1:0]     frame_lim;
  logic [FRAME_W-1:0]   sel;
  logic [PROD_W-1:0]    prod;
  logic [FRAME_W-1:0]   q_base;
  logic [FRAME_W-1:0]   sel_off;
  logic [CFG_W-1:0]     remain;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_vec;
  logic [WORD_BITS-1:0] low_bit;
  logic [BIT_W-1:0]     idx;
  logic [CFG_W:0]       chk_end;
  logic [FRAME_W-1:0]   grant_frame;
  logic [WORD_BITS-1:0] clear_mask;
  logic                 rd_ok;
  logic                 mem_we;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  assign frame_lim = (cfg_frames_r < CFG_W'(MAP_FRAMES)) ? cfg_frames_r : CFG_W'(MAP_FRAMES);
  assign sel       = (cmd_r == CMD_FREE) ? entry_r : query_r;
  assign prod      = PROD_W'(sel) * PROD_W'(RECIP_C);
  assign q_base    = FRAME_W'(q_r) * FRAME_W'(WORD_BITS);
  assign sel_off   = sel - q_base;

  assign remain = (chk_base_r < frame_lim) ? (frame_lim - chk_base_r) : '0;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = remain > CFG_W'(i);
    end
  end

  assign free_vec = ~rdata_r & mask;
  assign low_bit  = free_vec & (~free_vec + WORD_BITS'(1));

  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        idx = BIT_W'(i);
      end
    end
  end

  assign chk_end     = {1'b0, chk_base_r} + (CFG_W + 1)'(WORD_BITS);
  assign grant_frame = chk_base_r[FRAME_W-1:0] + FRAME_W'(idx);
  assign clear_mask  = ~(WORD_BITS'(1) << rem_r);
  assign rd_ok       = rd_idx_r < CNT_W'(MAP_DEPTH);

  assign mem_we    = ctl.clear | ctl.free_wr | ctl.alloc_wr;
  assign mem_waddr = ctl.clear ? clr_idx_r : (ctl.free_wr ? q_r : chk_idx_r);
  assign mem_wdata = ctl.clear ? '0 : (ctl.free_wr ? (rdata_r & clear_mask) : (rdata_r | low_bit));
  assign mem_re    = ctl.lookup | (ctl.scan & rd_ok);
  assign mem_raddr = ctl.lookup ? q_r : rd_idx_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= map_mem[mem_raddr];
    end
  end

  // Latched command fields and the word/bit split of the addressed frame.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r   <= in_command;
      entry_r <= in_entry_frame;
      query_r <= in_query_frame;
      kern_r  <= in_is_kernel;
      wr_r    <= in_is_writable;
    end
    q_r <= prod[SH +: ADDR_W];
    if (ctl.lookup) begin
      rem_r <= sel_off[BIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= CFG_RESET;
      clr_idx_r    <= '0;
      rd_idx_r     <= '0;
      rd_base_r    <= '0;
      chk_idx_r    <= '0;
      chk_base_r   <= '0;
      chk_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_frames_r <= cfg_wdata;
      end
      if (ctl.clear) begin
        clr_idx_r <= clr_idx_r + ADDR_W'(1);
      end
      if (ctl.accept) begin
        rd_idx_r  <= '0;
        rd_base_r <= '0;
        chk_vld_r <= 1'b0;
      end else if (ctl.scan) begin
        rd_idx_r   <= rd_idx_r + CNT_W'(1);
        rd_base_r  <= rd_base_r + CFG_W'(WORD_BITS);
        chk_idx_r  <= rd_idx_r[ADDR_W-1:0];
        chk_base_r <= rd_base_r;
        chk_vld_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      status_r    <= STAT_OK;
      new_frame_r <= '0;
      present_r   <= 1'b0;
      user_r      <= 1'b0;
      writable_r  <= 1'b0;
      used_r      <= 1'b0;
      case (ctl.res_kind)
        RES_MAPPED:  status_r <= STAT_MAPPED;
        RES_NO_FREE: status_r <= STAT_NO_FREE;
        RES_RANGE:   status_r <= STAT_RANGE;
        RES_ALLOC: begin
          new_frame_r <= grant_frame;
          present_r   <= 1'b1;
          user_r      <= ~kern_r;
          writable_r  <= wr_r;
        end
        RES_TEST:    used_r <= rdata_r[rem_r];
        default:     status_r <= STAT_OK;
      endcase
    end
  end

  assign stat.clear_last = clr_idx_r == ADDR_W'(MAP_DEPTH - 1);
  assign stat.cmd        = cmd_r;
  assign stat.entry_nz   = |entry_r;
  assign stat.in_range   = CFG_W'(sel) < frame_lim;
  assign stat.chk_vld    = chk_vld_r;
  assign stat.found      = |free_vec;
  assign stat.last_word  = chk_end >= {1'b0, frame_lim};

  assign out_status      = status_r;
  assign out_new_frame   = new_frame_r;
  assign out_present     = present_r;
  assign out_user_access = user_r;
  assign out_writable    = writable_r;
  assign out_frame_used  = used_r;

  `FBA_ASSERT(a_alloc_in_range, (ctl.finish && ctl.res_kind == RES_ALLOC) |=> (CFG_W'(out_new_frame) < frame_lim), "allocated frame lies outside the searched range")
  `FBA_ASSERT(a_free_after_lookup, ctl.free_wr |-> $past(ctl.lookup), "free write-back without a preceding word read")

endmodule

`default_nettype wire

// File: src/fba_ctrl.sv
// Controller of the frame bitmap allocator: sequences the clearing sweep,
// command decode, word lookup and bitmap scan. Uses fba_pkg.
`default_nettype none
`include "assert_macros.svh"

module fba_ctrl import fba_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  output logic           out_valid,
  output fba_ctl_t       ctl,
  input  wire fba_stat_t stat
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_CHECK,
    ST_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   done_r;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.cmd)
          CMD_ALLOC: begin
            if (stat.entry_nz) begin
              ctl.finish   = 1'b1;
              ctl.res_kind = RES_MAPPED;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          CMD_FREE, CMD_TEST: begin
            if (!stat.in_range) begin
              ctl.finish   = 1'b1;
              ctl.res_kind = RES_RANGE;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt = ST_LOOKUP;
            end
          end
          default: begin
            ctl.finish   = 1'b1;
            ctl.res_kind = RES_ZERO;
            state_nxt    = ST_IDLE;
          end
        endcase
      end
      ST_LOOKUP: begin
        ctl.lookup = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        ctl.finish = 1'b1;
        if (stat.cmd == CMD_FREE) begin
          ctl.free_wr  = 1'b1;
          ctl.res_kind = RES_ZERO;
        end else begin
          ctl.res_kind = RES_TEST;
        end
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (stat.chk_vld && stat.found) begin
          ctl.alloc_wr = 1'b1;
          ctl.finish   = 1'b1;
          ctl.res_kind = RES_ALLOC;
          state_nxt    = ST_IDLE;
        end else if (stat.chk_vld && stat.last_word) begin
          ctl.finish   = 1'b1;
          ctl.res_kind = RES_NO_FREE;
          state_nxt    = ST_IDLE;
        end else begin
          ctl.scan = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy_nxt = state_nxt != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      done_r  <= ctl.finish;
    end
  end

  assign busy      = busy_r;
  assign out_valid = done_r;

  `FBA_ASSERT(a_strobe_single, done_r |=> !done_r, "result strobe lasted more than one cycle")
  `FBA_ASSERT(a_accept_decode, (start && !busy_r) |=> (state_r == ST_DECODE), "accepted transaction did not enter decode")
  `FBA_ASSERT(a_result_from_work, done_r |-> ($past(state_r) != ST_IDLE), "result strobe without a transaction in progress")
  `FBA_ASSERT(a_busy_matches_state, busy_r == (state_r != ST_IDLE), "busy disagrees with controller state")

endmodule

`default_nettype wire
